// File: sv/rle_pkg.sv
package rle_pkg;

    localparam int unsigned COLOR_W = 8;
    localparam int unsigned COUNT_W = 8;

    // output queue: a pixel may leave two runs behind it
    localparam int unsigned OQ_DEPTH = 4;
    localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int unsigned OQ_CNT_W = OQ_PTR_W + 1;

    typedef struct packed {
        logic [COUNT_W-1:0] run_count;
        logic [COLOR_W-1:0] run_red;
        logic [COLOR_W-1:0] run_green;
        logic [COLOR_W-1:0] run_blue;
        logic               final_run;
    } run_item_t;

    typedef struct packed {
        logic [1:0] push_n;
        run_item_t  slot0;
        run_item_t  slot1;
    } run_push_t;

endpackage

// File: sv/rle_if.sv
interface rle_pixel_if;
    import rle_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_red;
    logic [COLOR_W-1:0] pixel_green;
    logic [COLOR_W-1:0] pixel_blue;
    logic               block_end;

    modport source (output valid, pixel_red, pixel_green, pixel_blue, block_end,
                    input ready);
    modport sink   (input valid, pixel_red, pixel_green, pixel_blue, block_end,
                    output ready);
endinterface

interface rle_run_if;
    import rle_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] run_count;
    logic [COLOR_W-1:0] run_red;
    logic [COLOR_W-1:0] run_green;
    logic [COLOR_W-1:0] run_blue;
    logic               final_run;

    modport source (output valid, run_count, run_red, run_green, run_blue, final_run,
                    input ready);
    modport sink   (input valid, run_count, run_red, run_green, run_blue, final_run,
                    output ready);
endinterface

// File: sv/rle_core.sv
module rle_core
    import rle_pkg::*;
#(
    parameter int unsigned MAX_RUN = 255
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [COLOR_W-1:0] pixel_red,
    input  logic [COLOR_W-1:0] pixel_green,
    input  logic [COLOR_W-1:0] pixel_blue,
    input  logic               block_end,
    output run_push_t          push
);

    logic               open_reg,  open_next;
    logic [COUNT_W-1:0] len_reg,   len_next;
    logic [COLOR_W-1:0] red_reg,   red_next;
    logic [COLOR_W-1:0] green_reg, green_next;
    logic [COLOR_W-1:0] blue_reg,  blue_next;

    logic      same;
    logic      extend;
    logic      closing;
    run_item_t closed_run;
    run_item_t final_item;

    assign same = open_reg && pixel_red == red_reg && pixel_green == green_reg
                  && pixel_blue == blue_reg;
    assign extend  = same && (len_reg < COUNT_W'(MAX_RUN));
    assign closing = open_reg && !extend;

    always_comb
    begin
        if (extend)
        begin
            len_next   = len_reg + COUNT_W'(1);
            red_next   = red_reg;
            green_next = green_reg;
            blue_next  = blue_reg;
        end
        else
        begin
            len_next   = COUNT_W'(1);
            red_next   = pixel_red;
            green_next = pixel_green;
            blue_next  = pixel_blue;
        end
        open_next = 1'b1;

        closed_run = '{run_count: len_reg, run_red: red_reg, run_green: green_reg,
                       run_blue: blue_reg, final_run: 1'b0};
        final_item = '{run_count: len_next, run_red: red_next, run_green: green_next,
                       run_blue: blue_next, final_run: 1'b1};

        push.slot1 = final_item;
        if (closing)
        begin
            push.slot0 = closed_run;
        end
        else
        begin
            push.slot0 = final_item;
        end
        push.push_n = 2'(closing) + 2'(block_end);
        if (!accept)
        begin
            push.push_n = 2'd0;
        end

        // block end flushes the run and leaves nothing open
        if (block_end)
        begin
            open_next = 1'b0;
            len_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            len_reg   <= '0;
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
        end
        else if (accept)
        begin
            open_reg  <= open_next;
            len_reg   <= len_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

endmodule

// File: sv/rle_outq.sv
module rle_outq
    import rle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  run_push_t push,
    output logic      room,
    output logic      out_valid,
    input  logic      out_ready,
    output run_item_t out_item
);

    run_item_t             mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0]   cnt_reg,    cnt_next;
    logic                  pop;

    assign out_valid = cnt_reg != '0;
    assign out_item  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // room for the worst case of two results
    assign room      = cnt_reg <= OQ_CNT_W'(OQ_DEPTH - 2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OQ_PTR_W'(push.push_n);
        rd_ptr_next = rd_ptr_reg + OQ_PTR_W'(pop);
        cnt_next    = cnt_reg + OQ_CNT_W'(push.push_n) - OQ_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.push_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.slot0;
        end
        if (push.push_n == 2'd2)
        begin
            mem[wr_ptr_reg + OQ_PTR_W'(1)] <= push.slot1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: sv/rgb_run_length_encoder_unit.sv
// RGB run-length encoder: takes one 24-bit pixel per cycle and emits runs as
// a count (1..MAX_RUN) plus the run color; a pixel flagged block_end flushes
// the open run, the last run carrying final_run, so one pixel may yield up
// to two runs. The run state updates in the cycle a pixel is accepted; its
// runs go to a 4-entry output queue that drains one run per cycle while
// run.ready is high. Pixel ready stays high as long as the queue has two
// free entries, so pixels are taken one per cycle while run output keeps pace.
module rgb_run_length_encoder_unit
    import rle_pkg::*;
#(
    parameter int unsigned MAX_RUN = 255
)
(
    input  logic         clk,
    input  logic         rst_n,
    rle_pixel_if.sink    pixel,
    rle_run_if.source    run
);

    run_push_t push;
    run_item_t out_item;
    logic      room;
    logic      accept;

    assign pixel.ready = room;
    assign accept      = pixel.valid && room;

    rle_core #(
        .MAX_RUN (MAX_RUN)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel_red   (pixel.pixel_red),
        .pixel_green (pixel.pixel_green),
        .pixel_blue  (pixel.pixel_blue),
        .block_end   (pixel.block_end),
        .push        (push)
    );

    rle_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (run.valid),
        .out_ready (run.ready),
        .out_item  (out_item)
    );

    assign run.run_count = out_item.run_count;
    assign run.run_red   = out_item.run_red;
    assign run.run_green = out_item.run_green;
    assign run.run_blue  = out_item.run_blue;
    assign run.final_run = out_item.final_run;

endmodule

// File: sv/rle_checker.sv
module rle_checker
    import rle_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               in_block_end,
    input logic               out_valid,
    input logic               out_ready,
    input logic [COUNT_W-1:0] out_count,
    input logic               out_final
);

    // a block end always leaves a final run queued
    a_end_gives_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_block_end |=> out_valid)
        else $error("no run after block end");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_count != '0)
        else $error("run with zero count");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("run item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_count) && $stable(out_final))
        else $error("stalled run item changed");

endmodule

bind rgb_run_length_encoder_unit rle_checker u_rle_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (pixel.valid),
    .in_ready     (pixel.ready),
    .in_block_end (pixel.block_end),
    .out_valid    (run.valid),
    .out_ready    (run.ready),
    .out_count    (run.run_count),
    .out_final    (run.final_run)
);
